>>> src/rgb_to_palette_nearest_core_macros.svh
// assertion macros for the rgb to palette nearest core
// clocked on clk, disabled while rst_n is low; no other dependencies
`ifndef RGB_TO_PALETTE_NEAREST_CORE_MACROS_SVH
`define RGB_TO_PALETTE_NEAREST_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RTPN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTPN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RTPN_ASSERT_NOW(label, ante, cons, msg)
`define RTPN_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> src/rtpn_pkg.sv
// shared types and constants for the rgb to palette nearest core
// no dependencies
`default_nettype none

package rtpn_pkg;

  localparam int PAL_ENTRIES  = 240;
  localparam int CUBE_ENTRIES = 216;
  localparam int CUBE_SIDE    = 6;
  localparam int GREY_BASE    = 8;
  localparam int GREY_STEP    = 10;

  localparam int CH_W   = 8;
  localparam int DIST_W = 10;
  localparam int IDX_W  = 8;

  localparam logic [DIST_W-1:0] DIST_START  = 10'd765;
  localparam logic [IDX_W-1:0]  CODE_OFFSET = 8'd16;

  localparam logic [CH_W-1:0] CUBE_LEVEL [CUBE_SIDE] = '{
    8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
  };

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // what travels down the chain with each pixel
  typedef struct packed {
    rgb_t              pix;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } stage_t;

endpackage

`default_nettype wire

>>> src/rgb_to_palette_nearest_core.sv
// channel   | handshake           | payload
// in_       | in_valid, in_stall  | in_red, in_green, in_blue (8 bits each)
// out_      | out_valid, out_stall| out_color_code (8 bits, 16..255)
//
// one pixel per clock while in_stall is low; from accept to result a pixel passes
// through 240 chain cells, one per palette entry, and then the output register.
// reset clears only valid bits; there is no clearing pass.
// a result held by out_stall parks in the output register, the next one in a
// skid slot; while the skid slot is full the whole chain holds and in_stall is high.
// uses rtpn_pkg, rtpn_cell, rtpn_oreg and the assertion macro header
`default_nettype none

`include "rgb_to_palette_nearest_core_macros.svh"

module rgb_to_palette_nearest_core
  import rtpn_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [CH_W-1:0] in_red,
  input  wire logic [CH_W-1:0] in_green,
  input  wire logic [CH_W-1:0] in_blue,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [IDX_W-1:0]     out_color_code
);

  logic   pipe_en;
  logic   skid_full;
  logic   chain_valid [PAL_ENTRIES+1];
  stage_t chain_data  [PAL_ENTRIES+1];

  assign in_stall = !pipe_en;

  assign chain_valid[0]              = in_valid;
  assign chain_data[0].pix.red       = in_red;
  assign chain_data[0].pix.green     = in_green;
  assign chain_data[0].pix.blue      = in_blue;
  assign chain_data[0].best_dist     = DIST_START;
  assign chain_data[0].best_idx      = '0;

  for (genvar i = 0; i < PAL_ENTRIES; i++) begin : g_cell
    localparam int RI = (i / (CUBE_SIDE * CUBE_SIDE)) % CUBE_SIDE;
    localparam int GI = (i / CUBE_SIDE) % CUBE_SIDE;
    localparam int BI = i % CUBE_SIDE;
    localparam logic [CH_W-1:0] GV = CH_W'(GREY_BASE + GREY_STEP * (i - CUBE_ENTRIES));
    localparam bit IS_CUBE = (i < CUBE_ENTRIES);

    rgb_t entry;

    assign entry = IS_CUBE ? rgb_t'{CUBE_LEVEL[RI], CUBE_LEVEL[GI], CUBE_LEVEL[BI]}
                           : rgb_t'{GV, GV, GV};

    rtpn_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (pipe_en),
      .entry      (entry),
      .entry_idx  (IDX_W'(i)),
      .prev_valid (chain_valid[i]),
      .prev_data  (chain_data[i]),
      .next_valid (chain_valid[i+1]),
      .next_data  (chain_data[i+1])
    );
  end

  rtpn_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (chain_valid[PAL_ENTRIES]),
    .pipe_idx   (chain_data[PAL_ENTRIES].best_idx),
    .pipe_en    (pipe_en),
    .out_valid  (out_valid),
    .out_code   (out_color_code),
    .out_stall  (out_stall),
    .skid_full  (skid_full)
  );

  // skid slot only fills behind a held output
  `RTPN_ASSERT_NOW(a_skid_behind_out, skid_full, out_valid,
                   "skid slot full without a pending result")

  // draining the skid slot leaves the result in the output register
  `RTPN_ASSERT_NEXT(a_skid_drain, skid_full && !out_stall, out_valid && !skid_full,
                    "skid slot did not drain into the output register")

  // a valid result always carries a code past the system colors
  `RTPN_ASSERT_NOW(a_code_range, out_valid, out_color_code >= CODE_OFFSET,
                   "color code below the palette offset")

  // the chain only stops when a result is waiting on the far side
  `RTPN_ASSERT_NEXT(a_stall_cause, !skid_full && !out_valid, !in_stall,
                    "input stalled with an empty output side")

endmodule

`default_nettype wire

>>> src/rtpn_cell.sv
// one cell of the search chain: compares the passing pixel against one palette entry
// uses rtpn_pkg
`default_nettype none

module rtpn_cell
  import rtpn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire rgb_t             entry,
  input  wire logic [IDX_W-1:0] entry_idx,
  input  wire logic             prev_valid,
  input  wire stage_t           prev_data,
  output logic                  next_valid,
  output stage_t                next_data
);

  logic              valid_r;
  logic              valid_nxt;
  stage_t            data_r;
  stage_t            data_nxt;
  logic [CH_W-1:0]   ad_red;
  logic [CH_W-1:0]   ad_green;
  logic [CH_W-1:0]   ad_blue;
  logic [DIST_W-1:0] entry_dist;

  always_comb begin
    ad_red   = (prev_data.pix.red > entry.red) ? prev_data.pix.red - entry.red
                                               : entry.red - prev_data.pix.red;
    ad_green = (prev_data.pix.green > entry.green) ? prev_data.pix.green - entry.green
                                                   : entry.green - prev_data.pix.green;
    ad_blue  = (prev_data.pix.blue > entry.blue) ? prev_data.pix.blue - entry.blue
                                                 : entry.blue - prev_data.pix.blue;
    entry_dist = DIST_W'(ad_red) + DIST_W'(ad_green) + DIST_W'(ad_blue);
  end

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (en) begin
      valid_nxt = prev_valid;
      data_nxt  = prev_data;
      // strictly smaller only, so the lower index keeps a tie
      if (entry_dist < prev_data.best_dist) begin
        data_nxt.best_dist = entry_dist;
        data_nxt.best_idx  = entry_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign next_valid = valid_r;
  assign next_data  = data_r;

endmodule

`default_nettype wire

>>> src/rtpn_oreg.sv
// output register plus skid slot at the end of the chain
// uses rtpn_pkg
`default_nettype none

module rtpn_oreg
  import rtpn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pipe_valid,
  input  wire logic [IDX_W-1:0] pipe_idx,
  output logic                  pipe_en,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_code,
  input  wire logic             out_stall,
  output logic                  skid_full
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [IDX_W-1:0] out_code_r;
  logic [IDX_W-1:0] out_code_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  logic [IDX_W-1:0] skid_code_r;
  logic [IDX_W-1:0] skid_code_nxt;
  logic [IDX_W-1:0] pipe_code;
  logic             take;

  assign pipe_code = pipe_idx + CODE_OFFSET;
  assign take      = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_code_nxt   = out_code_r;
    skid_valid_nxt = skid_valid_r;
    skid_code_nxt  = skid_code_r;
    if (skid_valid_r) begin
      // chain is frozen; drain the skid slot first
      if (take) begin
        out_code_nxt   = skid_code_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (pipe_valid) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_code_nxt  = pipe_code;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_code_nxt  = pipe_code;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r  <= out_code_nxt;
    skid_code_r <= skid_code_nxt;
  end

  assign pipe_en   = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign skid_full = skid_valid_r;

endmodule

`default_nettype wire
